@@ hdl/life_3d_cell_automaton_unit_defines.svh @@
// ----------------------------------------------------------------------------
// life_3d_cell_automaton_unit_defines.svh
// Assertion macros for the 3D life cell automaton unit.
// ----------------------------------------------------------------------------
`ifndef LIFE_3D_CELL_AUTOMATON_UNIT_DEFINES_SVH
`define LIFE_3D_CELL_AUTOMATON_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define L3D_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("life3d: assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define L3D_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("life3d: assertion failed");

`endif

@@ hdl/life3d_pkg.sv @@
// ----------------------------------------------------------------------------
// life3d_pkg
// Shared types, constants and helpers of the 3D life cell automaton.
// ----------------------------------------------------------------------------
package life3d_pkg;

   localparam int SIZE_X = 8;
   localparam int SIZE_Y = 8;
   localparam int SIZE_Z = 8;

   localparam int XW = $clog2(SIZE_X);
   localparam int YW = $clog2(SIZE_Y);
   localparam int ZW = $clog2(SIZE_Z);

   localparam int ROW_AW    = ZW + YW;
   localparam int RAM_AW    = ROW_AW + 1;
   localparam int RAM_DEPTH = 2 ** RAM_AW;

   localparam int CNT_W   = 5;
   localparam int COORD_W = 3;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [CNT_W-1:0] LIVE_MIN_RESET = 5'd9;
   localparam logic [CNT_W-1:0] LIVE_MAX_RESET = 5'd17;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;

   localparam logic REG_LIVE_MIN = 1'b0;
   localparam logic REG_LIVE_MAX = 1'b1;

   typedef struct packed {
      logic [1:0]         operation;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_z;
      logic               write_alive;
   } req_type;

   typedef struct packed {
      logic cell_alive;
      logic step_done;
   } rsp_type;

   typedef logic [SIZE_X-1:0]            row_type;
   typedef logic [SIZE_X-1:0][1:0]       lane_sum_type;
   typedef logic [SIZE_X-1:0][CNT_W-1:0] lane_cnt_type;

   typedef struct packed {
      logic accumulate;
      logic clear;
   } count_ctl_type;

   typedef struct packed {
      logic              wr_en;
      logic [RAM_AW-1:0] wr_addr;
      row_type           wr_data;
      logic              rd_en;
      logic [RAM_AW-1:0] rd_addr;
   } ram_req_type;

   // live cells at x-1, x, x+1 of one row, wrapped
   function automatic lane_sum_type lane_sum(row_type row);
      lane_sum_type s;
      int           lo;
      int           hi;
      for (int i = 0; i < SIZE_X; i++) begin
         lo   = (i == 0) ? SIZE_X - 1 : i - 1;
         hi   = (i == SIZE_X - 1) ? 0 : i + 1;
         s[i] = 2'(row[lo]) + 2'(row[i]) + 2'(row[hi]);
      end
      return s;
   endfunction

endpackage

@@ hdl/life3d_ram.sv @@
// ----------------------------------------------------------------------------
// life3d_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module life3d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/life3d_count.sv @@
// ----------------------------------------------------------------------------
// life3d_count
// Per-lane neighborhood counter for one row; accumulates nine row reads and
// applies the live bounds to give the next-generation row.
// ----------------------------------------------------------------------------
module life3d_count (
   input  logic                           clock,
   input  life3d_pkg::count_ctl_type      ctl,
   input  life3d_pkg::row_type            row_data,
   input  logic [life3d_pkg::CNT_W-1:0]   live_min,
   input  logic [life3d_pkg::CNT_W-1:0]   live_max,
   output life3d_pkg::row_type            next_row
);

   life3d_pkg::lane_cnt_type acc_ff;
   life3d_pkg::lane_cnt_type acc_in;
   life3d_pkg::lane_cnt_type sum;
   life3d_pkg::lane_sum_type lanes;

   always_comb begin
      lanes = life3d_pkg::lane_sum(row_data);
      for (int i = 0; i < life3d_pkg::SIZE_X; i++) begin
         sum[i]      = acc_ff[i] + life3d_pkg::CNT_W'(lanes[i]);
         next_row[i] = (sum[i] >= live_min) && (sum[i] <= live_max);
      end
      priority if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.accumulate) begin
         acc_in = sum;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

@@ hdl/life3d_seq.sv @@
// ----------------------------------------------------------------------------
// life3d_seq
// Sequencer: handshakes, voxel read/write, clearing pass and the row sweep
// of a generation advance over the double-buffered grid.
// ----------------------------------------------------------------------------
module life3d_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  life3d_pkg::req_type         req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output life3d_pkg::rsp_type         rsp_data,
   output life3d_pkg::ram_req_type     ram,
   input  life3d_pkg::row_type         rd_data,
   output life3d_pkg::count_ctl_type   count_ctl,
   input  life3d_pkg::row_type         next_row
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_WR    = 3'd2;
   localparam logic [2:0] S_RD    = 3'd3;
   localparam logic [2:0] S_ADV   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   localparam int XW = life3d_pkg::XW;
   localparam int YW = life3d_pkg::YW;
   localparam int ZW = life3d_pkg::ZW;

   logic [2:0]                     state_ff, state_in;
   logic                           bank_ff, bank_in;
   logic [XW-1:0]                  x_ff, x_in;
   logic [YW-1:0]                  y_ff, y_in;
   logic [ZW-1:0]                  z_ff, z_in;
   logic                           wbit_ff, wbit_in;
   logic [1:0]                     dy_ff, dy_in;
   logic [1:0]                     dz_ff, dz_in;
   logic                           issue_done_ff, issue_done_in;
   logic                           rd_pend_ff, rd_pend_in;
   logic                           last_pend_ff, last_pend_in;
   logic [life3d_pkg::ROW_AW-1:0]  clr_ff, clr_in;
   life3d_pkg::rsp_type            pend_ff, pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   life3d_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                           in_cube;
   logic                           out_free;
   logic                           last_row;
   logic [YW-1:0]                  ny;
   logic [ZW-1:0]                  nz;
   life3d_pkg::row_type            wr_row;

   assign in_cube = (32'(req_data.pos_x) < life3d_pkg::SIZE_X)
                 && (32'(req_data.pos_y) < life3d_pkg::SIZE_Y)
                 && (32'(req_data.pos_z) < life3d_pkg::SIZE_Z);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_row = (z_ff == ZW'(life3d_pkg::SIZE_Z - 1))
                  && (y_ff == YW'(life3d_pkg::SIZE_Y - 1));

   always_comb begin
      unique case (dy_ff)
         2'd0:    ny = (y_ff == '0) ? YW'(life3d_pkg::SIZE_Y - 1) : y_ff - 1'b1;
         2'd1:    ny = y_ff;
         default: ny = (y_ff == YW'(life3d_pkg::SIZE_Y - 1)) ? '0 : y_ff + 1'b1;
      endcase
      unique case (dz_ff)
         2'd0:    nz = (z_ff == '0) ? ZW'(life3d_pkg::SIZE_Z - 1) : z_ff - 1'b1;
         2'd1:    nz = z_ff;
         default: nz = (z_ff == ZW'(life3d_pkg::SIZE_Z - 1)) ? '0 : z_ff + 1'b1;
      endcase
      wr_row       = rd_data;
      wr_row[x_ff] = wbit_ff;
   end

   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      wbit_in       = wbit_ff;
      dy_in         = dy_ff;
      dz_in         = dz_ff;
      issue_done_in = issue_done_ff;
      rd_pend_in    = 1'b0;
      last_pend_in  = 1'b0;
      clr_in        = clr_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram           = '0;
      count_ctl     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram.wr_en   = 1'b1;
            ram.wr_addr = {1'b0, clr_ff};
            ram.wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               x_in    = XW'(req_data.pos_x);
               y_in    = YW'(req_data.pos_y);
               z_in    = ZW'(req_data.pos_z);
               wbit_in = req_data.write_alive;
               pend_in = '0;
               unique case (req_data.operation)
                  life3d_pkg::OP_WRITE, life3d_pkg::OP_READ: begin
                     if (in_cube) begin
                        ram.rd_en   = 1'b1;
                        ram.rd_addr = {bank_ff, ZW'(req_data.pos_z), YW'(req_data.pos_y)};
                        state_in    = (req_data.operation == life3d_pkg::OP_WRITE)
                                    ? S_WR : S_RD;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  life3d_pkg::OP_ADVANCE: begin
                     y_in            = '0;
                     z_in            = '0;
                     dy_in           = 2'd0;
                     dz_in           = 2'd0;
                     issue_done_in   = 1'b0;
                     count_ctl.clear = 1'b1;
                     state_in        = S_ADV;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_WR: begin
            ram.wr_en   = 1'b1;
            ram.wr_addr = {bank_ff, z_ff, y_ff};
            ram.wr_data = wr_row;
            state_in    = S_DONE;
         end
         S_RD: begin
            pend_in.cell_alive = rd_data[x_ff];
            pend_in.step_done  = 1'b0;
            state_in           = S_DONE;
         end
         S_ADV: begin
            if (!issue_done_ff) begin
               ram.rd_en    = 1'b1;
               ram.rd_addr  = {bank_ff, nz, ny};
               rd_pend_in   = 1'b1;
               last_pend_in = (dy_ff == 2'd2) && (dz_ff == 2'd2);
               if (dy_ff == 2'd2) begin
                  dy_in = 2'd0;
                  if (dz_ff == 2'd2) begin
                     dz_in         = 2'd0;
                     issue_done_in = 1'b1;
                  end else begin
                     dz_in = dz_ff + 2'd1;
                  end
               end else begin
                  dy_in = dy_ff + 2'd1;
               end
            end
            count_ctl.accumulate = rd_pend_ff;
            if (last_pend_ff) begin
               count_ctl.clear = 1'b1;
               ram.wr_en       = 1'b1;
               ram.wr_addr     = {~bank_ff, z_ff, y_ff};
               ram.wr_data     = next_row;
               issue_done_in   = 1'b0;
               if (last_row) begin
                  bank_in           = ~bank_ff;
                  pend_in.cell_alive = 1'b0;
                  pend_in.step_done  = 1'b1;
                  state_in          = S_DONE;
               end else if (y_ff == YW'(life3d_pkg::SIZE_Y - 1)) begin
                  y_in = '0;
                  z_in = z_ff + 1'b1;
               end else begin
                  y_in = y_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         bank_ff       <= 1'b0;
         clr_ff        <= '0;
         issue_done_ff <= 1'b0;
         rd_pend_ff    <= 1'b0;
         last_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_ff       <= bank_in;
         clr_ff        <= clr_in;
         issue_done_ff <= issue_done_in;
         rd_pend_ff    <= rd_pend_in;
         last_pend_ff  <= last_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      wbit_ff     <= wbit_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/life_3d_cell_automaton_unit.sv @@
// ----------------------------------------------------------------------------
// life_3d_cell_automaton_unit
// 3D life automaton on a toroidal voxel cube. The grid lives in one RAM, one
// x-row per word, with two banks for the current and next generation. A
// write or read beat goes from accept to result through a row read, then a
// modify-write or bit select, then the output register, which waits while
// the previous result is stalled. In an advance each row needs nine row
// reads through the single RAM read port, summed lane-wise by the shared
// counter, then a bound compare and write-back. After reset a clearing
// pass zeroes the current bank before the first beat is taken; the live
// bounds can be written meanwhile.
// ----------------------------------------------------------------------------
module life_3d_cell_automaton_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  life3d_pkg::req_type              req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output life3d_pkg::rsp_type              rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [life3d_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [life3d_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [life3d_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                             csr_pready
);

   localparam int CW = life3d_pkg::CNT_W;

   logic [CW-1:0]             live_min_ff, live_min_in;
   logic [CW-1:0]             live_max_ff, live_max_in;
   logic                      csr_wr;
   logic                      csr_sel;
   life3d_pkg::ram_req_type   ram;
   life3d_pkg::row_type       rd_data;
   life3d_pkg::count_ctl_type count_ctl;
   life3d_pkg::row_type       next_row;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_paddr[2];

   always_comb begin
      live_min_in = live_min_ff;
      live_max_in = live_max_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            life3d_pkg::REG_LIVE_MIN: live_min_in = csr_pwdata[CW-1:0];
            life3d_pkg::REG_LIVE_MAX: live_max_in = csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
      unique case (csr_sel)
         life3d_pkg::REG_LIVE_MIN: csr_prdata = life3d_pkg::CSR_DW'(live_min_ff);
         life3d_pkg::REG_LIVE_MAX: csr_prdata = life3d_pkg::CSR_DW'(live_max_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_min_ff <= life3d_pkg::LIVE_MIN_RESET;
         live_max_ff <= life3d_pkg::LIVE_MAX_RESET;
      end else begin
         live_min_ff <= live_min_in;
         live_max_ff <= live_max_in;
      end
   end

   life3d_ram #(
      .WIDTH (life3d_pkg::SIZE_X),
      .DEPTH (life3d_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram.wr_en),
      .wr_addr (ram.wr_addr),
      .wr_data (ram.wr_data),
      .rd_en   (ram.rd_en),
      .rd_addr (ram.rd_addr),
      .rd_data (rd_data)
   );

   life3d_count u_count (
      .clock    (clock),
      .ctl      (count_ctl),
      .row_data (rd_data),
      .live_min (live_min_ff),
      .live_max (live_max_ff),
      .next_row (next_row)
   );

   life3d_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .ram       (ram),
      .rd_data   (rd_data),
      .count_ctl (count_ctl),
      .next_row  (next_row)
   );

endmodule

@@ hdl/life3d_checker.sv @@
// ----------------------------------------------------------------------------
// life3d_checker
// Port-level checks of the 3D life cell automaton unit, bound to the top.
// ----------------------------------------------------------------------------
`include "life_3d_cell_automaton_unit_defines.svh"

module life3d_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input life3d_pkg::req_type              req_data,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input life3d_pkg::rsp_type              rsp_data,
   input logic                             csr_psel,
   input logic                             csr_penable,
   input logic                             csr_pwrite,
   input logic [life3d_pkg::CSR_AW-1:0]    csr_paddr,
   input logic [life3d_pkg::CSR_DW-1:0]    csr_pwdata,
   input logic [life3d_pkg::CSR_DW-1:0]    csr_prdata,
   input logic                             csr_pready
);

   // a stalled result beat holds
   `L3D_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // every accepted op raises the stall after its accept
   `L3D_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // a result never flags both a live cell and a finished advance
   `L3D_ASSERT_IMPLY(a_one_flag, rsp_valid, !(rsp_data.cell_alive && rsp_data.step_done))

   // a new result only appears while an op is in flight
   `L3D_ASSERT_IMPLY(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall))

endmodule

bind life_3d_cell_automaton_unit life3d_checker u_life3d_checker (.*);
